[src/fbfc_pkg.sv]
// ----------------------------------------------------------------------------
// fbfc_pkg
// Shared widths, types and register indexes of the force ball facet clearance
// block.
// ----------------------------------------------------------------------------
package fbfc_pkg;

  localparam int DataW   = 32;
  localparam int NumVals = 6;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 32;
  localparam int MinW    = 48;

  localparam logic [CfgIdxW-1:0] CFG_DIMS_USED    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCALE_FACTOR = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_NORM_FLOOR   = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } fbfc_unit_sts_t;

endpackage

[src/fbfc_if.sv]
// ----------------------------------------------------------------------------
// fbfc interfaces
// Valid/ready channels for column items, results and register writes.
// ----------------------------------------------------------------------------
interface fbfc_in_if
  import fbfc_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [DataW-1:0] value_0;
  logic signed [DataW-1:0] value_1;
  logic signed [DataW-1:0] value_2;
  logic signed [DataW-1:0] value_3;
  logic signed [DataW-1:0] value_4;
  logic signed [DataW-1:0] value_5;
  logic signed [DataW-1:0] radius;
  logic signed [DataW-1:0] upper_limit;
  logic signed [DataW-1:0] lower_limit;
  logic                    last;

  modport source (output valid, op, value_0, value_1, value_2, value_3, value_4,
                  value_5, radius, upper_limit, lower_limit, last, input ready);
  modport sink (input valid, op, value_0, value_1, value_2, value_3, value_4,
                value_5, radius, upper_limit, lower_limit, last, output ready);
endinterface

interface fbfc_out_if
  import fbfc_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] clearance;
  logic                    any_facet;
  logic                    saturated;

  modport source (output valid, clearance, any_facet, saturated, input ready);
  modport sink (input valid, clearance, any_facet, saturated, output ready);
endinterface

interface fbfc_cfg_if
  import fbfc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] idx;
  logic [CfgDatW-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

[src/fbfc_isqrt.sv]
// ----------------------------------------------------------------------------
// fbfc_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module fbfc_isqrt
  import fbfc_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [63:0]    radicand_i,
  output fbfc_unit_sts_t sts_o,
  output logic [31:0]    root_o
);

  logic [63:0] x_q, x_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [35:0] rem_t;
  logic [35:0] trial;

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_t  = {rem_q, x_q[63:62]};
    trial  = {2'b00, root_q, 2'b01};
    if (start_i && !busy_q) begin
      x_d    = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d = {x_q[61:0], 2'b00};
      if (rem_t >= trial) begin
        rem_d  = 34'(rem_t - trial);
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_t[33:0];
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign sts_o  = '{busy: busy_q, done: done_q};
  assign root_o = root_q;

endmodule

[src/fbfc_div.sv]
// ----------------------------------------------------------------------------
// fbfc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbfc_div
  import fbfc_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [65:0]    dividend_i,
  input  logic [31:0]    divisor_i,
  output fbfc_unit_sts_t sts_o,
  output logic [65:0]    quotient_o
);

  logic [65:0] dq_q, dq_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] rem_t;

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_t  = {rem_q, dq_q[65]};
    if (start_i && !busy_q) begin
      dq_d   = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_t >= {2'b00, dvs_q}) begin
        rem_d = 33'(rem_t - {2'b00, dvs_q});
        dq_d  = {dq_q[64:0], 1'b1};
      end else begin
        rem_d = rem_t[32:0];
        dq_d  = {dq_q[64:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd65) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign sts_o      = '{busy: busy_q, done: done_q};
  assign quotient_o = dq_q;

endmodule

[src/force_ball_facet_clearance.sv]
// ----------------------------------------------------------------------------
// force_ball_facet_clearance
// Signed clearance between a force ball and a box-limited torque polytope.
// ----------------------------------------------------------------------------
// Channels: in_i takes items, out_o returns results, cfg_i writes registers.
// An op 0 item loads the ball centre and radius. An op 1 item
// carries one Jacobian column; the block is busy until its work is done.
// Column work: 2*dims+2 products on the shared 33x33 multiplier, then
// the bit-serial square root and a check state; a skipped column ends
// there, and a counted column then takes two passes of the bit-serial
// divider, one pass per facet, the upper facet first, then the lower.
// The item with last set produces one result into an output register; the
// next item is accepted while it waits. If the receiver stalls with a
// result still held, the next result waits in the sequencer until the
// register frees.
// Reset restores the register defaults, clears the ball and the running
// minimum. Register writes are taken while the block is idle.
// ----------------------------------------------------------------------------
module force_ball_facet_clearance
  import fbfc_pkg::*;
#(
  parameter int MAX_DIMS  = 6,
  parameter int FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  fbfc_in_if.sink    in_i,
  fbfc_out_if.source out_o,
  fbfc_cfg_if.sink   cfg_i
);

  localparam int StW = $clog2(2 * MAX_DIMS + 3);
  localparam int KW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int Shl = (FRAC_BITS >= 18) ? FRAC_BITS - 18 : 0;
  localparam int Shr = (FRAC_BITS < 18) ? 18 - FRAC_BITS : 0;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_SQRT   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_DIV_GO = 3'd4;
  localparam logic [2:0] S_DIV_WT = 3'd5;
  localparam logic [2:0] S_END    = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  localparam logic [1:0] KIND_SQ    = 2'd0;
  localparam logic [1:0] KIND_CROSS = 2'd1;
  localparam logic [1:0] KIND_BU    = 2'd2;
  localparam logic [1:0] KIND_BL    = 2'd3;

  localparam logic signed [MinW-1:0] MAX48 = {1'b0, {(MinW-1){1'b1}}};
  localparam logic signed [MinW-1:0] MIN48 = {1'b1, {(MinW-1){1'b0}}};

  logic [2:0]  state_q, state_d;
  logic [2:0]  dims_cfg_q;
  logic [18:0] scale_q;
  logic [16:0] floor_q;

  logic signed [DataW-1:0] centre_q [MAX_DIMS];
  logic        [DataW-1:0] radius_q;
  logic signed [DataW-1:0] vals_q [MAX_DIMS];
  logic signed [DataW-1:0] in_vals [NumVals];
  logic signed [DataW-1:0] tu_q, tl_q;
  logic                    last_q;
  logic [2:0]              dims_q;

  logic [StW-1:0]      st_q;
  logic [StW-1:0]      nprod;
  logic [KW-1:0]       k_sel;
  logic [1:0]          kind;
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  prod_q;
  logic signed [65:0]  bound;
  logic [1:0]          pkind_q;
  logic                pvld_q;

  logic [63:0]         sum2_q;
  logic signed [63:0]  proj_q, bu_q, bl_q;
  logic [31:0]         h_q;
  logic                facet_lo_q;
  logic signed [MinW-1:0] min_q;
  logic                found_q;

  logic signed [64:0]  numer;
  logic [64:0]         mag;
  logic                neg_q;
  logic [47:0]         qc;
  logic signed [49:0]  sval;
  logic signed [MinW-1:0] s48;

  logic                sqrt_start, div_start;
  fbfc_unit_sts_t      sqrt_sts, div_sts;
  logic [31:0]         root;
  logic [65:0]         quot;

  logic                out_valid_q;
  logic signed [DataW-1:0] out_clr_q;
  logic                out_any_q, out_sat_q;
  logic                out_free;
  logic [2:0]          dims_eff;

  assign in_vals[0] = in_i.value_0;
  assign in_vals[1] = in_i.value_1;
  assign in_vals[2] = in_i.value_2;
  assign in_vals[3] = in_i.value_3;
  assign in_vals[4] = in_i.value_4;
  assign in_vals[5] = in_i.value_5;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_o.ready;

  always_comb begin
    if (dims_cfg_q == 3'd0) begin
      dims_eff = 3'd1;
    end else if (32'(dims_cfg_q) > MAX_DIMS) begin
      dims_eff = 3'(MAX_DIMS);
    end else begin
      dims_eff = dims_cfg_q;
    end
  end

  assign nprod = StW'({dims_q, 1'b0}) + StW'(2);
  assign k_sel = KW'(st_q >> 1);

  always_comb begin
    if (st_q == StW'({dims_q, 1'b0})) begin
      kind = KIND_BU;
    end else if (st_q == StW'({dims_q, 1'b0}) + StW'(1)) begin
      kind = KIND_BL;
    end else if (st_q[0]) begin
      kind = KIND_CROSS;
    end else begin
      kind = KIND_SQ;
    end
    case (kind)
      KIND_SQ: begin
        mul_a = 33'(vals_q[k_sel]);
        mul_b = 33'(vals_q[k_sel]);
      end
      KIND_CROSS: begin
        mul_a = 33'(vals_q[k_sel]);
        mul_b = 33'(centre_q[k_sel]);
      end
      KIND_BU: begin
        mul_a = {14'd0, scale_q};
        mul_b = 33'(tu_q);
      end
      default: begin
        mul_a = {14'd0, scale_q};
        mul_b = -33'(tl_q);
      end
    endcase
  end

  assign bound = (prod_q <<< Shl) >>> Shr;

  assign numer = facet_lo_q ? 65'(bl_q) + 65'(proj_q) : 65'(bu_q) - 65'(proj_q);
  assign mag   = numer[64] ? 65'(-numer) : 65'(numer);

  assign qc   = (quot > 66'(48'h8000_0000_0000)) ? 48'h8000_0000_0000 : quot[47:0];
  assign sval = (neg_q ? -$signed({2'b00, qc}) : $signed({2'b00, qc}))
                - $signed({18'd0, radius_q});
  always_comb begin
    if (sval > 50'(MAX48)) begin
      s48 = MAX48;
    end else if (sval < 50'(MIN48)) begin
      s48 = MIN48;
    end else begin
      s48 = sval[MinW-1:0];
    end
  end

  assign sqrt_start = (state_q == S_MUL) && (st_q == nprod) && !pvld_q;
  assign div_start  = (state_q == S_DIV_GO);

  fbfc_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sum2_q),
    .sts_o      (sqrt_sts),
    .root_o     (root)
  );

  fbfc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag, 1'b0}),
    .divisor_i  (h_q),
    .sts_o      (div_sts),
    .quotient_o (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid && in_i.op) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (sqrt_start) begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_sts.done) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if ({h_q, 1'b0} > {16'd0, floor_q}) begin
          state_d = S_DIV_GO;
        end else begin
          state_d = S_END;
        end
      end
      S_DIV_GO: state_d = S_DIV_WT;
      S_DIV_WT: begin
        if (div_sts.done) begin
          state_d = facet_lo_q ? S_END : S_DIV_GO;
        end
      end
      S_END: state_d = last_q ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dims_cfg_q  <= 3'd6;
      scale_q     <= 19'd65536;
      floor_q     <= 17'd1;
      radius_q    <= '0;
      min_q       <= MAX48;
      found_q     <= 1'b0;
      pvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_DIMS; i++) begin
        centre_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.idx)
          CFG_DIMS_USED:    dims_cfg_q <= cfg_i.data[2:0];
          CFG_SCALE_FACTOR: scale_q    <= cfg_i.data[18:0];
          CFG_NORM_FLOOR:   floor_q    <= cfg_i.data[16:0];
          default: ;
        endcase
      end
      if (state_q == S_IDLE && in_i.valid && !in_i.op) begin
        for (int i = 0; i < MAX_DIMS; i++) begin
          centre_q[i] <= in_vals[i];
        end
        radius_q <= in_i.radius[DataW-1] ? '0 : in_i.radius;
      end
      if (state_q == S_MUL) begin
        pvld_q <= (st_q != nprod);
      end else begin
        pvld_q <= 1'b0;
      end
      if (state_q == S_DIV_WT && div_sts.done) begin
        if (s48 < min_q) begin
          min_q <= s48;
        end
        if (facet_lo_q) begin
          found_q <= 1'b1;
        end
      end
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
        min_q       <= MAX48;
        found_q     <= 1'b0;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        vals_q[i] <= in_vals[i];
      end
      tu_q       <= in_i.upper_limit;
      tl_q       <= in_i.lower_limit;
      last_q     <= in_i.last;
      dims_q     <= dims_eff;
      st_q       <= '0;
      sum2_q     <= '0;
      proj_q     <= '0;
      facet_lo_q <= 1'b0;
    end
    if (state_q == S_MUL && st_q != nprod) begin
      prod_q  <= mul_a * mul_b;
      pkind_q <= kind;
      st_q    <= st_q + StW'(1);
    end
    if (pvld_q) begin
      case (pkind_q)
        KIND_SQ:    sum2_q <= sum2_q + 64'(prod_q >>> 2);
        KIND_CROSS: proj_q <= proj_q + 64'(prod_q >>> 2);
        KIND_BU:    bu_q   <= 64'(bound);
        default:    bl_q   <= 64'(bound);
      endcase
    end
    if (state_q == S_SQRT && sqrt_sts.done) begin
      h_q <= root;
    end
    if (state_q == S_DIV_GO) begin
      neg_q <= numer[64];
    end
    if (state_q == S_DIV_WT && div_sts.done) begin
      facet_lo_q <= 1'b1;
    end
    if (state_q == S_EMIT && out_free) begin
      out_any_q <= found_q;
      if (!found_q) begin
        out_clr_q <= '0;
        out_sat_q <= 1'b0;
      end else if (min_q > 48'sh0000_7FFF_FFFF) begin
        out_clr_q <= 32'sh7FFF_FFFF;
        out_sat_q <= 1'b1;
      end else if (min_q < -48'sh0000_8000_0000) begin
        out_clr_q <= 32'sh8000_0000;
        out_sat_q <= 1'b1;
      end else begin
        out_clr_q <= min_q[DataW-1:0];
        out_sat_q <= 1'b0;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.clearance = out_clr_q;
  assign out_o.any_facet = out_any_q;
  assign out_o.saturated = out_sat_q;

endmodule

[tb/sv/force_ball_facet_clearance_tb.sv]
// ----------------------------------------------------------------------------
// force_ball_facet_clearance_tb
// Drives ball loads and Jacobian columns with random gaps and output stalls,
// predicts each query's minimum facet clearance and checks every result.
// ----------------------------------------------------------------------------
module force_ball_facet_clearance_tb;
  import fbfc_pkg::*;

  localparam longint Max48 = 64'sh7FFF_FFFF_FFFF;
  localparam longint Min48 = -Max48 - 1;
  localparam int WatchLimit = 20000;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  typedef struct {
    logic        op;
    logic [31:0] vals [6];
    logic [31:0] radius;
    logic [31:0] upper_limit;
    logic [31:0] lower_limit;
    logic        last;
  } column_t;

  typedef struct {
    logic [31:0] clearance;
    logic        any_facet;
    logic        saturated;
  } clearance_t;

  logic clk_i;
  logic rst_ni;

  fbfc_in_if  in_i ();
  fbfc_out_if out_o ();
  fbfc_cfg_if cfg_i ();

  force_ball_facet_clearance dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .out_o (out_o),
    .cfg_i (cfg_i)
  );

  column_t    pending_q [$];
  clearance_t clearance_q [$];

  logic [2:0]  dims_used;
  logic [18:0] scale_factor;
  logic [16:0] norm_floor;
  longint      centre [6];
  longint      ball_radius;
  longint      running_min;
  logic        found_facet;

  int mismatches;
  int gap_cnt;
  int stall_cnt;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint floor_div4(longint v);
    return v >>> 2;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint facet_margin(longint numer, longint h);
    longint unsigned mag;
    longint unsigned q;
    longint s;
    mag = numer < 0 ? -numer : numer;
    q = (mag * 2) / longint'(h);
    if (q > (64'd1 << 47)) q = 64'd1 << 47;
    s = numer < 0 ? -longint'(q) : longint'(q);
    s -= ball_radius;
    if (s > Max48) s = Max48;
    if (s < Min48) s = Min48;
    return s;
  endfunction

  function automatic void predict_clearance(column_t c);
    int dims;
    longint unsigned sum2;
    longint proj;
    longint x;
    longint h;
    longint bu;
    longint bl;
    longint cu;
    longint cl;
    clearance_t r;
    if (!c.op) begin
      for (int k = 0; k < 6; k++) centre[k] = longint'(signed'(c.vals[k]));
      ball_radius = longint'(signed'(c.radius));
      if (ball_radius < 0) ball_radius = 0;
      return;
    end
    dims = int'(dims_used);
    if (dims < 1) dims = 1;
    if (dims > 6) dims = 6;
    sum2 = 0;
    proj = 0;
    for (int k = 0; k < dims; k++) begin
      x = longint'(signed'(c.vals[k]));
      sum2 += longint'(x * x) >> 2;
      proj += floor_div4(x * centre[k]);
    end
    h = int_sqrt(sum2);
    if (2 * h > longint'(norm_floor)) begin
      bu = (longint'(scale_factor) * longint'(signed'(c.upper_limit))) >>> 2;
      bl = (longint'(scale_factor) * -longint'(signed'(c.lower_limit))) >>> 2;
      cu = facet_margin(bu - proj, h);
      cl = facet_margin(bl + proj, h);
      if (cu < running_min) running_min = cu;
      if (cl < running_min) running_min = cl;
      found_facet = 1'b1;
    end
    if (!c.last) return;
    r = '{32'd0, 1'b0, 1'b0};
    if (found_facet) begin
      r.any_facet = 1'b1;
      if (running_min > 64'sd2147483647) begin
        r.clearance = 32'h7FFF_FFFF;
        r.saturated = 1'b1;
      end else if (running_min < -64'sd2147483648) begin
        r.clearance = 32'h8000_0000;
        r.saturated = 1'b1;
      end else begin
        r.clearance = running_min[31:0];
      end
    end
    clearance_q = {clearance_q, r};
    running_min = Max48;
    found_facet = 1'b0;
  endfunction

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: return ($urandom_range(0, 3) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic column_t make_item(logic op, logic last, int mode);
    column_t c;
    c.op = op;
    c.last = last;
    for (int k = 0; k < 6; k++) c.vals[k] = rand_word(mode);
    c.radius = rand_word(mode);
    c.upper_limit = rand_word(mode);
    c.lower_limit = rand_word(mode);
    return c;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_i.valid <= 1'b1;
    cfg_i.idx <= idx;
    cfg_i.data <= data;
    do @(posedge clk_i); while (!cfg_i.ready);
    cfg_i.valid <= 1'b0;
    if (idx == CFG_DIMS_USED) dims_used = data[2:0];
    else if (idx == CFG_SCALE_FACTOR) scale_factor = data[18:0];
    else if (idx == CFG_NORM_FLOOR) norm_floor = data[16:0];
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_i.valid || clearance_q.size() != 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic queue_queries(int n, int mode);
    int cols;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        pending_q = {pending_q, make_item(1'b0, 1'($urandom()), mode)};
      cols = $urandom_range(1, 4);
      for (int j = 0; j < cols; j++)
        pending_q = {pending_q, make_item(1'b1, j == cols - 1, mode)};
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_i.valid <= 1'b0;
      gap_cnt <= 0;
    end else if (in_i.valid && !in_i.ready) begin
    end else if (gap_cnt > 0) begin
      in_i.valid <= 1'b0;
      gap_cnt <= gap_cnt - 1;
    end else if (pending_q.size() != 0) begin
      column_t c;
      c = pending_q.pop_front();
      predict_clearance(c);
      in_i.valid <= 1'b1;
      in_i.op <= c.op;
      in_i.value_0 <= c.vals[0];
      in_i.value_1 <= c.vals[1];
      in_i.value_2 <= c.vals[2];
      in_i.value_3 <= c.vals[3];
      in_i.value_4 <= c.vals[4];
      in_i.value_5 <= c.vals[5];
      in_i.radius <= c.radius;
      in_i.upper_limit <= c.upper_limit;
      in_i.lower_limit <= c.lower_limit;
      in_i.last <= c.last;
      gap_cnt <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
    end else begin
      in_i.valid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.ready <= 1'b0;
      stall_cnt <= 0;
      idle_cycles <= 0;
    end else begin
      if ((in_i.valid && in_i.ready) || (out_o.valid && out_o.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_o.valid && out_o.ready) begin
        if (clearance_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %0d", out_o.clearance);
        end else begin
          clearance_t e;
          e = clearance_q.pop_front();
          if (e.clearance !== out_o.clearance || e.any_facet !== out_o.any_facet ||
              e.saturated !== out_o.saturated) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected %h/%b/%b actual %h/%b/%b", e.clearance,
                       e.any_facet, e.saturated, out_o.clearance, out_o.any_facet,
                       out_o.saturated);
          end
        end
      end
      if (stall_cnt > 0) begin
        out_o.ready <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else begin
        out_o.ready <= 1'b1;
        if (out_o.valid && out_o.ready)
          stall_cnt <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    column_t c;
    mismatches = 0;
    rst_ni = 1'b0;
    cfg_i.valid = 1'b0;
    cfg_i.idx = CFG_DIMS_USED;
    cfg_i.data = '0;
    in_i.op = 1'b0;
    in_i.value_0 = '0;
    in_i.value_1 = '0;
    in_i.value_2 = '0;
    in_i.value_3 = '0;
    in_i.value_4 = '0;
    in_i.value_5 = '0;
    in_i.radius = '0;
    in_i.upper_limit = '0;
    in_i.lower_limit = '0;
    in_i.last = 1'b0;
    dims_used = 3'd6;
    scale_factor = 19'd65536;
    norm_floor = 17'd1;
    for (int k = 0; k < 6; k++) centre[k] = 0;
    ball_radius = 0;
    running_min = Max48;
    found_facet = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, negative radius, skipped columns, empty query
    c = make_item(1'b0, 1'b1, 1);
    c.radius = 32'hFFFF_0000;
    pending_q = {pending_q, c};
    c = make_item(1'b1, 1'b1, 1);
    for (int k = 0; k < 6; k++) c.vals[k] = '0;
    pending_q = {pending_q, c};
    c = make_item(1'b1, 1'b0, 3);
    pending_q = {pending_q, c};
    c = make_item(1'b1, 1'b1, 1);
    c.upper_limit = 32'h7FFF_FFFF;
    c.lower_limit = 32'h8000_0000;
    pending_q = {pending_q, c};
    c = make_item(1'b0, 1'b0, 3);
    c.radius = 32'h7FFF_FFFF;
    pending_q = {pending_q, c};
    for (int i = 0; i < 4; i++) pending_q = {pending_q, make_item(1'b1, i[0], 3)};
    c = make_item(1'b0, 1'b0, 0);
    c.radius = 32'h8000_0000;
    pending_q = {pending_q, c};
    for (int i = 0; i < 4; i++) pending_q = {pending_q, make_item(1'b1, i[0], 0)};
    drain();

    write_reg(CFG_DIMS_USED, 32'd1);
    write_reg(CFG_SCALE_FACTOR, 32'd262144);
    write_reg(CFG_NORM_FLOOR, 32'd65536);
    queue_queries(25, 1);
    drain();

    write_reg(CFG_DIMS_USED, 32'd0);
    write_reg(CFG_SCALE_FACTOR, 32'd0);
    write_reg(CFG_NORM_FLOOR, 32'd0);
    queue_queries(20, 2);
    drain();

    write_reg(CFG_DIMS_USED, 32'd7);
    write_reg(CFG_SCALE_FACTOR, 32'h7FFFF);
    write_reg(CFG_NORM_FLOOR, 32'h1FFFF);
    queue_queries(25, 0);
    drain();

    write_reg(CFG_DIMS_USED, 32'd3);
    write_reg(CFG_SCALE_FACTOR, 32'd65536);
    write_reg(CFG_NORM_FLOOR, 32'd1);
    write_reg(CfgIdxSpare, 32'hFFFF_FFFF);
    queue_queries(25, 2);
    queue_queries(20, 3);
    queue_queries(25, 1);
    drain();

    if (mismatches == 0 && clearance_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
